/* design/sample_bound_violation_monitor_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sample bound violation monitor
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_BOUND_VIOLATION_MONITOR_UNIT_ASSERT_SVH
`define SAMPLE_BOUND_VIOLATION_MONITOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svm assertion failed");
// Next-cycle implication.
`define SVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svm assertion failed");
`else
`define SVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/svm_pkg.sv */
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, codes and helpers of the sample bound violation monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svm_pkg;

  localparam int MAX_SAMPLES_DEF = 65536;
  localparam int VALUE_BITS_DEF  = 32;
  localparam int MID_DEPTH       = 4;
  localparam int OUT_DEPTH       = 8;

  localparam int RES_W     = 40;
  localparam int SUM_W     = 48;
  localparam int WIDE_W    = 52;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_W     = 16;
  localparam int TOT_W     = 17;
  localparam int SLACK_W   = 31;

  localparam logic [2:0] MODE_LOWER     = 3'd0;
  localparam logic [2:0] MODE_UPPER     = 3'd1;
  localparam logic [2:0] MODE_INTERVAL  = 3'd2;
  localparam logic [2:0] MODE_SUM_EQ    = 3'd3;
  localparam logic [2:0] MODE_SUM_RANGE = 3'd4;
  localparam logic [2:0] MODE_FINITE    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_GOAL        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLACK           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_LOW_ENABLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_HIGH_ENABLE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LIMIT    = 3'd7;

  // 1.0 in Q24.16
  localparam logic [RES_W-1:0] RES_ONE = 40'h00_0001_0000;

  typedef struct packed {
    logic [2:0]          check_mode;
    logic signed [31:0]  low_bound;
    logic signed [31:0]  high_bound;
    logic signed [31:0]  sum_goal;
    logic [SLACK_W-1:0]  slack;
    logic                sum_low_enable;
    logic                sum_high_enable;
    logic [NUM_W-1:0]    record_limit;
  } cfg_t;

  // Finished sample handed from front to back
  typedef struct packed {
    logic [RES_W-1:0]        excess;
    logic signed [SUM_W-1:0] sum;
    logic                    saw_invalid;
    logic                    saw_element;
    logic                    batch_end;
  } smp_t;

  typedef struct packed {
    logic [NUM_W-1:0] sample_number;
    logic [RES_W-1:0] sample_residual;
    logic             violated;
    logic             recorded;
    logic             batch_done;
    logic             all_admissible;
    logic [TOT_W-1:0] violation_total;
    logic [TOT_W-1:0] checked_total;
    logic [RES_W-1:0] largest_residual;
  } res_t;

  // Clamp a signed difference to [0, 2^40-1]
  function automatic logic [RES_W-1:0] pos40(input logic signed [WIDE_W-1:0] d);
    logic [RES_W-1:0] r;
    if (d[WIDE_W-1] || d == '0) begin
      r = '0;
    end else if (|d[WIDE_W-2:RES_W]) begin
      r = '1;
    end else begin
      r = d[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/svm_fifo.sv */
// ----------------------------------------------------------------------------
// svm_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sample_bound_violation_monitor_unit_assert.svh"

module svm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               wdata,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
  assign rdata = mem_r[rd_ptr_r];

  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `SVM_ASSERT_IMP(a_fifo_bound, clk, rst_n, 1'b1, cnt_r <= (AW+1)'(DEPTH))
  `SVM_ASSERT_NXT(a_fifo_grow, clk, rst_n, do_wr && !do_rd, cnt_r == $past(cnt_r) + (AW+1)'(1))

endmodule

/* design/svm_front.sv */
// ----------------------------------------------------------------------------
// svm_front
// Accept elements, fold bound excess and sum per sample, queue finished samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sample_bound_violation_monitor_unit_assert.svh"

module svm_front #(
  parameter int VALUE_BITS = svm_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  svm_pkg::cfg_t                 cfg,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [VALUE_BITS-1:0]  in_element,
  input  logic                          in_element_present,
  input  logic                          in_element_invalid,
  input  logic                          in_sample_end,
  input  logic                          in_batch_end,
  output logic                          smp_push,
  output svm_pkg::smp_t                 smp_word,
  input  logic                          smp_full
);

  import svm_pkg::*;

  logic [RES_W-1:0]        exc_r, exc_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    inv_r, inv_nxt;
  logic                    seen_r, seen_nxt;

  logic                    accept, sample_end;
  logic signed [WIDE_W-1:0] elem_w, lo_w, hi_w;
  logic [RES_W-1:0]        lo_exc, hi_exc;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_sat;

  assign in_full    = smp_full;
  assign accept     = in_push && !smp_full;
  assign sample_end = in_sample_end || in_batch_end;

  assign elem_w = WIDE_W'(in_element);
  assign lo_w   = WIDE_W'(cfg.low_bound);
  assign hi_w   = WIDE_W'(cfg.high_bound);
  assign lo_exc = pos40(lo_w - elem_w);
  assign hi_exc = pos40(elem_w - hi_w);

  // One extra bit catches overflow; clamp to the 48-bit signed limits
  assign sum_ext = (SUM_W+1)'(sum_r) + (SUM_W+1)'(in_element);
  always_comb begin
    if (sum_ext[SUM_W] == sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W-1:0];
    end else if (!sum_ext[SUM_W]) begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end
  end

  always_comb begin
    exc_nxt  = exc_r;
    sum_nxt  = sum_r;
    inv_nxt  = inv_r;
    seen_nxt = seen_r;
    if (in_element_present) begin
      seen_nxt = 1'b1;
      if (in_element_invalid) begin
        inv_nxt = 1'b1;
      end else begin
        if (cfg.check_mode != MODE_UPPER && lo_exc > exc_nxt) begin
          exc_nxt = lo_exc;
        end
        if (cfg.check_mode != MODE_LOWER && hi_exc > exc_nxt) begin
          exc_nxt = hi_exc;
        end
        sum_nxt = sum_sat;
      end
    end
  end

  assign smp_push             = accept && sample_end;
  assign smp_word.excess      = exc_nxt;
  assign smp_word.sum         = sum_nxt;
  assign smp_word.saw_invalid = inv_nxt;
  assign smp_word.saw_element = seen_nxt;
  assign smp_word.batch_end   = in_batch_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exc_r  <= '0;
      sum_r  <= '0;
      inv_r  <= 1'b0;
      seen_r <= 1'b0;
    end else if (accept) begin
      if (sample_end) begin
        exc_r  <= '0;
        sum_r  <= '0;
        inv_r  <= 1'b0;
        seen_r <= 1'b0;
      end else begin
        exc_r  <= exc_nxt;
        sum_r  <= sum_nxt;
        inv_r  <= inv_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  `SVM_ASSERT_NXT(a_front_clear, clk, rst_n, accept && sample_end, !seen_r && exc_r == '0)

endmodule

/* design/svm_back.sv */
// ----------------------------------------------------------------------------
// svm_back
// Turn queued samples into residuals, flags and batch totals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sample_bound_violation_monitor_unit_assert.svh"

module svm_back #(
  parameter int MAX_SAMPLES = svm_pkg::MAX_SAMPLES_DEF,
  parameter int OUT_DEPTH   = svm_pkg::OUT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  svm_pkg::cfg_t               cfg,
  input  logic                        smp_empty,
  input  svm_pkg::smp_t               smp_word,
  output logic                        smp_pop,
  input  logic [$clog2(OUT_DEPTH):0]  out_count,
  input  logic                        out_full,
  output logic                        out_push,
  output svm_pkg::res_t               out_word
);

  import svm_pkg::*;

  localparam int OCW = $clog2(OUT_DEPTH) + 1;
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_SAMPLES);
  localparam logic [CW-1:0] MAX_M1 = CW'(MAX_SAMPLES - 1);

  // Stage 1: sum differences
  logic                     v1_r;
  logic signed [WIDE_W-1:0] d3_r, dlo_r, dhi_r;
  logic [RES_W-1:0]         exc1_r;
  logic                     inv1_r, seen1_r, be1_r;

  // Stage 2: residual
  logic                     v2_r;
  logic [RES_W-1:0]         res2_r, res_nxt;
  logic                     be2_r;

  // Batch state
  logic [CW-1:0]            sc_r, sc_nxt;
  logic [CW-1:0]            vc_r, vc_nxt;
  logic [RES_W-1:0]         bmax_r, bmax_nxt;

  logic [OCW:0]             occ;
  logic signed [WIDE_W-1:0] sum_w, tol_w;
  logic [RES_W-1:0]         eq_res, lo_res, hi_res, rng_res;
  logic                     viol, rec;
  logic [CW-1:0]            idx;
  logic [CW+NUM_W-1:0]      idx_w;
  logic [CW+TOT_W-1:0]      vt_w, ct_w;

  // Hold a slot in the output queue for every sample in flight
  assign occ     = (OCW+1)'(out_count) + (OCW+1)'(v1_r) + (OCW+1)'(v2_r);
  assign smp_pop = !smp_empty && (occ < (OCW+1)'(OUT_DEPTH));

  assign sum_w = WIDE_W'(smp_word.sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= smp_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_pop) begin
      d3_r    <= sum_w - WIDE_W'(cfg.sum_goal);
      dlo_r   <= WIDE_W'(cfg.low_bound) - sum_w;
      dhi_r   <= sum_w - WIDE_W'(cfg.high_bound);
      exc1_r  <= smp_word.excess;
      inv1_r  <= smp_word.saw_invalid;
      seen1_r <= smp_word.saw_element;
      be1_r   <= smp_word.batch_end;
    end
  end

  assign tol_w  = $signed({{(WIDE_W-SLACK_W){1'b0}}, cfg.slack});
  assign eq_res = d3_r[WIDE_W-1] ? pos40(-d3_r - tol_w) : pos40(d3_r - tol_w);
  assign lo_res = cfg.sum_low_enable ? pos40(dlo_r - tol_w) : '0;
  assign hi_res = cfg.sum_high_enable ? pos40(dhi_r - tol_w) : '0;
  assign rng_res = (lo_res > hi_res) ? lo_res : hi_res;

  always_comb begin
    if (!seen1_r) begin
      res_nxt = RES_ONE;
    end else begin
      unique case (cfg.check_mode) inside
        MODE_LOWER, MODE_UPPER, MODE_INTERVAL: res_nxt = exc1_r;
        MODE_SUM_EQ:                           res_nxt = eq_res;
        MODE_SUM_RANGE:                        res_nxt = rng_res;
        MODE_FINITE:                           res_nxt = inv1_r ? RES_ONE : '0;
        default:                               res_nxt = RES_ONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      res2_r <= res_nxt;
      be2_r  <= be1_r;
    end
  end

  // Stage 3: counters and result word
  assign viol = (res2_r != '0);
  assign rec  = viol && ((CW+NUM_W)'(vc_r) < (CW+NUM_W)'(cfg.record_limit));
  assign idx  = (sc_r > MAX_M1) ? MAX_M1 : sc_r;

  assign sc_nxt   = (sc_r < MAX_C) ? sc_r + CW'(1) : sc_r;
  assign vc_nxt   = (viol && vc_r < MAX_C) ? vc_r + CW'(1) : vc_r;
  assign bmax_nxt = (res2_r > bmax_r) ? res2_r : bmax_r;

  assign idx_w = (CW+NUM_W)'(idx);
  assign vt_w  = (CW+TOT_W)'(vc_nxt);
  assign ct_w  = (CW+TOT_W)'(sc_nxt);

  assign out_push                 = v2_r;
  assign out_word.sample_number   = idx_w[NUM_W-1:0];
  assign out_word.sample_residual = res2_r;
  assign out_word.violated        = viol;
  assign out_word.recorded        = rec;
  assign out_word.batch_done      = be2_r;
  assign out_word.all_admissible  = be2_r && (vc_nxt == '0);
  assign out_word.violation_total = be2_r ? vt_w[TOT_W-1:0] : '0;
  assign out_word.checked_total   = be2_r ? ct_w[TOT_W-1:0] : '0;
  assign out_word.largest_residual = be2_r ? bmax_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r   <= '0;
      vc_r   <= '0;
      bmax_r <= '0;
    end else if (v2_r) begin
      if (be2_r) begin
        sc_r   <= '0;
        vc_r   <= '0;
        bmax_r <= '0;
      end else begin
        sc_r   <= sc_nxt;
        vc_r   <= vc_nxt;
        bmax_r <= bmax_nxt;
      end
    end
  end

  `SVM_ASSERT_IMP(a_back_room, clk, rst_n, out_push, !out_full)
  `SVM_ASSERT_IMP(a_back_rec, clk, rst_n, out_push && out_word.recorded, out_word.violated)
  `SVM_ASSERT_NXT(a_back_batch_clr, clk, rst_n, v2_r && be2_r, sc_r == '0 && vc_r == '0)

endmodule

/* design/sample_bound_violation_monitor_unit.sv */
// ----------------------------------------------------------------------------
// sample_bound_violation_monitor_unit
// Window comparator and limit checker over sampled Q16.16 state vectors.
// ----------------------------------------------------------------------------
// Elements enter one per cycle through a queue-style port (push/full) while
// in_full is low, and results leave through another (empty/pop). Each element
// is classified against the bounds as it arrives; when a word carries
// sample_end (or batch_end, which also closes the sample) one result word is
// produced with the sample residual, the violated and recorded flags, and, at
// a batch end, the batch totals. The block sustains one element per cycle
// while in_full is low and, for single-element samples, one result per cycle
// while the result queue has room. A result passes through the sample queue,
// the sum-difference register and the residual register before it is written
// into the result queue. The front accumulator's 48-bit saturating add and the
// back end's residual subtract set the clock period.
// Configuration registers are plain writes with no read-back; change them
// only while no sample is open and no result is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_bound_violation_monitor_unit #(
  parameter int MAX_SAMPLES = svm_pkg::MAX_SAMPLES_DEF,
  parameter int VALUE_BITS  = svm_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [svm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [svm_pkg::CFG_W-1:0]         cfg_data,
  // element input
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [VALUE_BITS-1:0]      in_element,
  input  logic                              in_element_present,
  input  logic                              in_element_invalid,
  input  logic                              in_sample_end,
  input  logic                              in_batch_end,
  // result output
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [svm_pkg::NUM_W-1:0]         out_sample_number,
  output logic [svm_pkg::RES_W-1:0]         out_sample_residual,
  output logic                              out_violated,
  output logic                              out_recorded,
  output logic                              out_batch_done,
  output logic                              out_all_admissible,
  output logic [svm_pkg::TOT_W-1:0]         out_violation_total,
  output logic [svm_pkg::TOT_W-1:0]         out_checked_total,
  output logic [svm_pkg::RES_W-1:0]         out_largest_residual
);

  import svm_pkg::*;

  localparam int SMP_W = $bits(smp_t);
  localparam int RES_WORD_W = $bits(res_t);

  cfg_t cfg_r;

  // Sample queue between front and back
  logic                         smp_push, smp_pop, smp_full, smp_empty;
  smp_t                         smp_wr, smp_rd;
  logic [SMP_W-1:0]             smp_rd_bits;
  logic [$clog2(MID_DEPTH):0]   smp_count;

  // Result queue
  logic                         res_push, res_full;
  res_t                         res_wr, res_rd;
  logic [RES_WORD_W-1:0]        res_rd_bits;
  logic [$clog2(OUT_DEPTH):0]   res_count;

  // Register file: decode the index, keep the low bits of the write data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHECK_MODE:      cfg_r.check_mode      <= cfg_data[2:0];
        REG_LOW_BOUND:       cfg_r.low_bound       <= $signed(cfg_data);
        REG_HIGH_BOUND:      cfg_r.high_bound      <= $signed(cfg_data);
        REG_SUM_GOAL:        cfg_r.sum_goal        <= $signed(cfg_data);
        REG_SLACK:           cfg_r.slack           <= cfg_data[SLACK_W-1:0];
        REG_SUM_LOW_ENABLE:  cfg_r.sum_low_enable  <= cfg_data[0];
        REG_SUM_HIGH_ENABLE: cfg_r.sum_high_enable <= cfg_data[0];
        REG_RECORD_LIMIT:    cfg_r.record_limit    <= cfg_data[NUM_W-1:0];
        default:             cfg_r <= cfg_r;
      endcase
    end
  end

  // Front: classify elements, push one word per finished sample
  svm_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_element         (in_element),
    .in_element_present (in_element_present),
    .in_element_invalid (in_element_invalid),
    .in_sample_end      (in_sample_end),
    .in_batch_end       (in_batch_end),
    .smp_push           (smp_push),
    .smp_word           (smp_wr),
    .smp_full           (smp_full)
  );

  // Decouple the element stream from result generation
  svm_fifo #(
    .W     (SMP_W),
    .DEPTH (MID_DEPTH)
  ) u_smp_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (smp_push),
    .wdata (smp_wr),
    .pop   (smp_pop),
    .rdata (smp_rd_bits),
    .full  (smp_full),
    .empty (smp_empty),
    .count (smp_count)
  );

  assign smp_rd = smp_t'(smp_rd_bits);

  // Back: residual, flags, batch totals
  svm_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .OUT_DEPTH   (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .smp_empty (smp_empty),
    .smp_word  (smp_rd),
    .smp_pop   (smp_pop),
    .out_count (res_count),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_word  (res_wr)
  );

  // Result queue; the back end reserves a slot before it pops a sample
  svm_fifo #(
    .W     (RES_WORD_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wr),
    .pop   (out_pop),
    .rdata (res_rd_bits),
    .full  (res_full),
    .empty (out_empty),
    .count (res_count)
  );

  assign res_rd = res_t'(res_rd_bits);

  assign out_sample_number    = res_rd.sample_number;
  assign out_sample_residual  = res_rd.sample_residual;
  assign out_violated         = res_rd.violated;
  assign out_recorded         = res_rd.recorded;
  assign out_batch_done       = res_rd.batch_done;
  assign out_all_admissible   = res_rd.all_admissible;
  assign out_violation_total  = res_rd.violation_total;
  assign out_checked_total    = res_rd.checked_total;
  assign out_largest_residual = res_rd.largest_residual;

endmodule

/* test/violation_result_checker.sv */
// ----------------------------------------------------------------------------
// violation_result_checker
// Watches the configuration, element and result ports of the bound violation
// monitor, predicts every result word from the accepted element words and
// compares each popped word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module violation_result_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [svm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [svm_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  in_push,
  input  logic                                  in_full,
  input  logic signed [svm_pkg::VALUE_BITS_DEF-1:0] in_element,
  input  logic                                  in_element_present,
  input  logic                                  in_element_invalid,
  input  logic                                  in_sample_end,
  input  logic                                  in_batch_end,
  input  logic                                  out_empty,
  input  logic                                  out_pop,
  input  logic [svm_pkg::NUM_W-1:0]             out_sample_number,
  input  logic [svm_pkg::RES_W-1:0]             out_sample_residual,
  input  logic                                  out_violated,
  input  logic                                  out_recorded,
  input  logic                                  out_batch_done,
  input  logic                                  out_all_admissible,
  input  logic [svm_pkg::TOT_W-1:0]             out_violation_total,
  input  logic [svm_pkg::TOT_W-1:0]             out_checked_total,
  input  logic [svm_pkg::RES_W-1:0]             out_largest_residual,
  output int                                    report_errors,
  output int                                    reports_due
);

  import svm_pkg::*;

  localparam longint SUM_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_BOTTOM = -SUM_TOP - 1;
  localparam longint RES_TOP    = 64'sh0000_00FF_FFFF_FFFF;

  cfg_t                    regs;
  logic [RES_W-1:0]        peak_excess;
  logic signed [SUM_W-1:0] running_sum;
  logic                    any_invalid;
  logic                    any_element;
  logic [TOT_W-1:0]        samples_seen;
  logic [TOT_W-1:0]        violations_seen;
  logic [RES_W-1:0]        batch_peak;
  res_t                    pending_reports[$];

  // Clip a signed distance to the unsigned 40-bit residual range.
  function automatic logic [RES_W-1:0] excess_of(input longint d);
    if (d <= 0) return '0;
    if (d > RES_TOP) return '1;
    return RES_W'(d);
  endfunction

  function automatic logic [RES_W-1:0] close_residual();
    longint total, lo, hi, tol, d;
    logic [RES_W-1:0] r;
    total = running_sum;
    lo = $signed(regs.low_bound);
    hi = $signed(regs.high_bound);
    tol = longint'(regs.slack);
    r = '0;
    if (!any_element) return RES_ONE;
    case (regs.check_mode) inside
      MODE_LOWER, MODE_UPPER, MODE_INTERVAL: r = peak_excess;
      MODE_SUM_EQ: begin
        d = total - $signed(regs.sum_goal);
        if (d < 0) d = -d;
        r = excess_of(d - tol);
      end
      MODE_SUM_RANGE: begin
        if (regs.sum_low_enable) r = excess_of(lo - total - tol);
        if (regs.sum_high_enable && excess_of(total - hi - tol) > r)
          r = excess_of(total - hi - tol);
      end
      MODE_FINITE: r = any_invalid ? RES_ONE : '0;
      default: r = RES_ONE;
    endcase
    return r;
  endfunction

  task automatic take_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_CHECK_MODE:      regs.check_mode = data[2:0];
      REG_LOW_BOUND:       regs.low_bound = data;
      REG_HIGH_BOUND:      regs.high_bound = data;
      REG_SUM_GOAL:        regs.sum_goal = data;
      REG_SLACK:           regs.slack = data[SLACK_W-1:0];
      REG_SUM_LOW_ENABLE:  regs.sum_low_enable = data[0];
      REG_SUM_HIGH_ENABLE: regs.sum_high_enable = data[0];
      REG_RECORD_LIMIT:    regs.record_limit = data[NUM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic fold_element(input logic signed [VALUE_BITS_DEF-1:0] value,
                              input logic present, input logic invalid,
                              input logic s_end, input logic b_end);
    longint x, lo, hi, total;
    logic [RES_W-1:0] res;
    logic viol;
    res_t r;
    x = value;
    lo = $signed(regs.low_bound);
    hi = $signed(regs.high_bound);
    if (present) begin
      any_element = 1'b1;
      if (invalid) begin
        any_invalid = 1'b1;
      end else begin
        if (regs.check_mode != MODE_UPPER && excess_of(lo - x) > peak_excess)
          peak_excess = excess_of(lo - x);
        if (regs.check_mode != MODE_LOWER && excess_of(x - hi) > peak_excess)
          peak_excess = excess_of(x - hi);
        total = running_sum + x;
        if (total > SUM_TOP) total = SUM_TOP;
        else if (total < SUM_BOTTOM) total = SUM_BOTTOM;
        running_sum = SUM_W'(total);
      end
    end
    // batch_end closes the sample on its own
    if (!(s_end || b_end)) return;

    res = close_residual();
    viol = (res != '0);
    r.sample_number = samples_seen[TOT_W-1] ? '1 : samples_seen[NUM_W-1:0];
    r.sample_residual = res;
    r.violated = viol;
    r.recorded = viol && (violations_seen < {1'b0, regs.record_limit});
    r.batch_done = b_end;
    if (samples_seen < TOT_W'(MAX_SAMPLES_DEF)) samples_seen++;
    if (viol && violations_seen < TOT_W'(MAX_SAMPLES_DEF)) violations_seen++;
    if (res > batch_peak) batch_peak = res;
    if (b_end) begin
      r.all_admissible = (violations_seen == '0);
      r.violation_total = violations_seen;
      r.checked_total = samples_seen;
      r.largest_residual = batch_peak;
      samples_seen = '0;
      violations_seen = '0;
      batch_peak = '0;
    end else begin
      r.all_admissible = 1'b0;
      r.violation_total = '0;
      r.checked_total = '0;
      r.largest_residual = '0;
    end
    pending_reports.insert(pending_reports.size(), r);
    peak_excess = '0;
    running_sum = '0;
    any_invalid = 1'b0;
    any_element = 1'b0;
  endtask

  function automatic void check_field(input string label, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      report_errors++;
    end
  endfunction

  task automatic match_report();
    res_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t: result word expected none, got sample_number %0h residual %0h",
               $time, out_sample_number, out_sample_residual);
      report_errors++;
      return;
    end
    want = pending_reports.pop_front();
    check_field("sample_number", 64'(want.sample_number), 64'(out_sample_number));
    check_field("sample_residual", 64'(want.sample_residual), 64'(out_sample_residual));
    check_field("violated", 64'(want.violated), 64'(out_violated));
    check_field("recorded", 64'(want.recorded), 64'(out_recorded));
    check_field("batch_done", 64'(want.batch_done), 64'(out_batch_done));
    check_field("all_admissible", 64'(want.all_admissible), 64'(out_all_admissible));
    check_field("violation_total", 64'(want.violation_total), 64'(out_violation_total));
    check_field("checked_total", 64'(want.checked_total), 64'(out_checked_total));
    check_field("largest_residual", 64'(want.largest_residual),
                64'(out_largest_residual));
  endtask

  // Sample the ports on the edge itself; the stimulus only changes them by NBA.
  // An element taken at the same edge as a register write still sees the old
  // register value.
  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '0;
      peak_excess = '0;
      running_sum = '0;
      any_invalid = 1'b0;
      any_element = 1'b0;
      samples_seen = '0;
      violations_seen = '0;
      batch_peak = '0;
      pending_reports.delete();
      report_errors = 0;
    end else begin
      if (in_push && !in_full)
        fold_element(in_element, in_element_present, in_element_invalid,
                     in_sample_end, in_batch_end);
      if (cfg_we) take_setting(cfg_index, cfg_data);
      if (out_pop && !out_empty) match_report();
    end
    reports_due <= pending_reports.size();
  end

endmodule

/* test/sample_bound_violation_monitor_unit_test.sv */
// ----------------------------------------------------------------------------
// sample_bound_violation_monitor_unit_test
// Drives element words and register settings into the bound violation monitor,
// idles both channels in several patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_bound_violation_monitor_unit_test;
  import svm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int RANDOM_WORDS   = 400;
  localparam int PHASE_WORDS    = 60;
  localparam int LONG_RUN       = 520;

  // check_mode values the block treats as undefined
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_TWO = 32'sh0002_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]              cfg_index = REG_CHECK_MODE;
  logic [CFG_W-1:0]                  cfg_data = '0;
  logic                              in_push = 1'b0;
  logic                              in_full;
  logic signed [VALUE_BITS_DEF-1:0]  in_element = '0;
  logic                              in_element_present = 1'b0;
  logic                              in_element_invalid = 1'b0;
  logic                              in_sample_end = 1'b0;
  logic                              in_batch_end = 1'b0;
  logic                              out_empty;
  logic                              out_pop = 1'b0;
  logic [NUM_W-1:0]                  out_sample_number;
  logic [RES_W-1:0]                  out_sample_residual;
  logic                              out_violated;
  logic                              out_recorded;
  logic                              out_batch_done;
  logic                              out_all_admissible;
  logic [TOT_W-1:0]                  out_violation_total;
  logic [TOT_W-1:0]                  out_checked_total;
  logic [RES_W-1:0]                  out_largest_residual;
  int                                report_errors;
  int                                reports_due;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   words_sent = 0;
  cfg_t active_cfg = '0;

  sample_bound_violation_monitor_unit i_dut (.*);

  violation_result_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: decide every cycle whether to take the head word; hold pop low
  // through reset.
  always @(posedge clk) out_pop <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);

  task automatic set_idling(input idle_mode_e m);
    send_idle_pct  = (m == IDLE_SENDER) ? 69 : (m == IDLE_BOTH) ? 36 : 0;
    recv_stall_pct = (m == IDLE_RECEIVER) ? 69 : (m == IDLE_BOTH) ? 36 : 0;
  endtask

  // Offer one element word and hold it until the block takes it. Push stays
  // high on return so back-to-back words need no second assignment per step.
  task automatic send_word(input logic signed [VALUE_BITS_DEF-1:0] value,
                           input logic present, input logic invalid,
                           input logic s_end, input logic b_end);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_element <= value;
    in_element_present <= present;
    in_element_invalid <= invalid;
    in_sample_end <= s_end;
    in_batch_end <= b_end;
    do @(posedge clk); while (in_full);
    words_sent++;
  endtask

  // Repeat one valid element; the end flags go on the last copy only.
  task automatic send_run(input logic signed [31:0] value, input int count,
                          input logic s_end, input logic b_end);
    for (int k = 1; k <= count; k++)
      send_word(value, 1'b1, 1'b0, s_end && k == count, b_end && k == count);
  endtask

  // Drop push, wait out every predicted word, then give the pipeline time to
  // drain any open work that produces no word.
  task automatic settle();
    in_push <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Write all eight registers; spare upper data bits carry noise the block
  // must drop.
  task automatic apply_settings(input cfg_t s);
    write_reg(REG_CHECK_MODE, {29'($urandom), s.check_mode});
    write_reg(REG_LOW_BOUND, s.low_bound);
    write_reg(REG_HIGH_BOUND, s.high_bound);
    write_reg(REG_SUM_GOAL, s.sum_goal);
    write_reg(REG_SLACK, {1'($urandom), s.slack});
    write_reg(REG_SUM_LOW_ENABLE, {31'($urandom), s.sum_low_enable});
    write_reg(REG_SUM_HIGH_ENABLE, {31'($urandom), s.sum_high_enable});
    write_reg(REG_RECORD_LIMIT, {16'($urandom), s.record_limit});
    cfg_we <= 1'b0;
    active_cfg = s;
  endtask

  function automatic logic signed [31:0] near_zero();
    return $signed(32'($urandom_range(0, 32'h8_0000))) - 32'sh4_0000;
  endfunction

  // Favor values close to the active bounds and goal so both outcomes occur.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] jitter;
    jitter = $signed(32'($urandom_range(0, 32'h4_0000))) - 32'sh2_0000;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return Q_MAX;
      2: return Q_MIN;
      3, 4: return $signed(active_cfg.low_bound) + jitter;
      5: return $signed(active_cfg.high_bound) + jitter;
      default: return ($signed(active_cfg.sum_goal) >>> 2) + jitter;
    endcase
  endfunction

  // The first two phases pin every register to an extreme; later ones draw.
  function automatic cfg_t draw_settings(input int phase);
    cfg_t s;
    s.check_mode = 3'($urandom_range(MODE_LOWER, MODE_FINITE));
    if ($urandom_range(0, 19) == 0) s.check_mode = $urandom_range(0, 1) ? MODE_SPARE_LO
                                                                        : MODE_SPARE_HI;
    case ($urandom_range(0, 3))
      0: begin
        s.low_bound = near_zero();
        s.high_bound = s.low_bound + 32'($urandom_range(0, 32'h6_0000));
      end
      1: begin
        s.low_bound = $urandom;
        s.high_bound = $urandom;
      end
      2: begin
        s.low_bound = Q_MIN + 32'($urandom_range(0, 32'h10_0000));
        s.high_bound = Q_MAX - 32'($urandom_range(0, 32'h10_0000));
      end
      default: begin
        // reversed window
        s.high_bound = near_zero();
        s.low_bound = s.high_bound + 32'($urandom_range(1, 32'h4_0000));
      end
    endcase
    s.sum_goal = ($urandom_range(0, 3) == 0) ? $urandom : near_zero();
    case ($urandom_range(0, 3))
      0: s.slack = '0;
      1: s.slack = '1;
      2: s.slack = 31'($urandom);
      default: s.slack = 31'($urandom_range(0, 32'h2_0000));
    endcase
    s.sum_low_enable = 1'($urandom);
    s.sum_high_enable = 1'($urandom);
    s.record_limit = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    if (phase == 0) begin
      s.check_mode = MODE_LOWER;
      s.low_bound = Q_MIN;
      s.high_bound = Q_MIN;
      s.sum_goal = Q_MIN;
      s.slack = '0;
      s.sum_low_enable = 1'b0;
      s.sum_high_enable = 1'b0;
      s.record_limit = '0;
    end else if (phase == 1) begin
      s.check_mode = MODE_SUM_RANGE;
      s.low_bound = Q_MAX;
      s.high_bound = Q_MAX;
      s.sum_goal = Q_MAX;
      s.slack = '1;
      s.sum_low_enable = 1'b1;
      s.sum_high_enable = 1'b1;
      s.record_limit = '1;
    end
    return s;
  endfunction

  // One sample of 0 to 6 elements with stray no-element words mixed in. The
  // closing flags ride on the last element or on a trailing no-element word;
  // a batch close sometimes comes without sample_end.
  task automatic send_random_sample(input logic closes_batch);
    int   n;
    logic tail_close, last, se, be;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    tail_close = (n == 0) || ($urandom_range(0, 5) == 0);
    be = closes_batch;
    se = !closes_batch || 1'($urandom);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 11) == 0) send_word($urandom, 1'b0, 1'($urandom), 1'b0, 1'b0);
      last = (k == n - 1) && !tail_close;
      send_word(pick_value(), 1'b1, $urandom_range(0, 9) == 0, last && se, last && be);
    end
    if (tail_close) send_word($urandom, 1'b0, 1'($urandom), se, be);
  endtask

  task automatic run_phase();
    int first;
    first = words_sent;
    while (words_sent - first < PHASE_WORDS) send_random_sample($urandom_range(0, 7) == 0);
    // close the batch so no sample stays open across a register write
    send_random_sample(1'b1);
  endtask

  initial begin
    cfg_t s;
    int   phase;
    int   first;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // Interval of +-1.0, one recorded violation per batch: extremes, inside,
    // empty sample, invalid-only sample, stray word, batch end alone.
    s = '0;
    s.check_mode = MODE_INTERVAL;
    s.low_bound = -Q_ONE;
    s.high_bound = Q_ONE;
    s.record_limit = 16'd1;
    apply_settings(s);
    send_word(Q_MAX, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(Q_MIN, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(32'sh0000_8000, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(32'sh1234_5678, 1'b0, 1'b1, 1'b1, 1'b0);
    send_word(Q_MAX, 1'b1, 1'b1, 1'b1, 1'b0);
    send_word(Q_TWO, 1'b0, 1'b0, 1'b0, 1'b0);
    send_word(Q_ONE, 1'b1, 1'b0, 1'b0, 1'b1);

    // Lower only: a huge element must not count.
    settle();
    s.check_mode = MODE_LOWER;
    apply_settings(s);
    send_word(-Q_TWO, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(Q_MAX, 1'b1, 1'b0, 1'b1, 1'b1);

    // Upper only: the most negative element must not count.
    settle();
    s.check_mode = MODE_UPPER;
    apply_settings(s);
    send_word(Q_MIN, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(Q_TWO + Q_ONE, 1'b1, 1'b0, 1'b0, 1'b1);

    // Sum equality: target 1.5 with 0.25 of slack.
    settle();
    s.check_mode = MODE_SUM_EQ;
    s.sum_goal = 32'sh0001_8000;
    s.slack = 31'h0000_4000;
    apply_settings(s);
    send_word(Q_ONE, 1'b1, 1'b0, 1'b0, 1'b0);
    send_word(Q_ONE, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(32'sh0001_8000, 1'b1, 1'b0, 1'b0, 1'b1);

    // Sum range with both enables off never violates.
    settle();
    s.check_mode = MODE_SUM_RANGE;
    s.low_bound = '0;
    s.slack = '0;
    apply_settings(s);
    send_word(Q_MAX, 1'b1, 1'b0, 1'b0, 1'b1);

    settle();
    s.sum_low_enable = 1'b1;
    s.sum_high_enable = 1'b1;
    apply_settings(s);
    send_word(-Q_ONE, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(Q_TWO, 1'b1, 1'b0, 1'b1, 1'b1);

    // Finite: one flagged element spoils the sample.
    settle();
    s.check_mode = MODE_FINITE;
    apply_settings(s);
    send_word(Q_MAX, 1'b1, 1'b1, 1'b0, 1'b0);
    send_word('0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(Q_ONE, 1'b1, 1'b0, 1'b0, 1'b1);

    // Undefined mode reports 1.0 for any sample.
    settle();
    s.check_mode = MODE_SPARE_HI;
    apply_settings(s);
    send_word('0, 1'b1, 1'b0, 1'b0, 1'b1);

    // Random phases, rotating through the idling patterns.
    phase = 0;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      settle();
      apply_settings(draw_settings(phase));
      set_idling(idle_mode_e'(phase % 4));
      run_phase();
      phase++;
    end

    // One long sample at full rate: the raw Q16.16 sum passes 2^40 (2^24 as a value),
    // so the residual pins at its top.
    settle();
    set_idling(IDLE_NONE);
    s = '0;
    s.check_mode = MODE_SUM_EQ;
    s.record_limit = '1;
    apply_settings(s);
    send_run(Q_MAX, LONG_RUN, 1'b1, 1'b1);

    settle();
    if (report_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: end the run once no word has moved on either channel for too
  // long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
